// ----- rtl/pip_pkg.sv -----
`timescale 1ns / 1ps

package pip_pkg;

    localparam int MAX_VERTICES_DEF = 64;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [15:0] coord_x;
        logic signed [15:0] coord_y;
    } t_pip_req;

    typedef struct packed {
        logic inside_res;
        logic overflowed;
    } t_pip_res;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
    } t_pip_vtx;

    // one edge handed to the crossing unit
    typedef struct packed {
        logic     vld;
        t_pip_vtx pa;
        t_pip_vtx pb;
    } t_pip_edge;

    typedef struct packed {
        logic busy;
        logic hit_vld;
        logic hit;
    } t_pip_sts;

endpackage

// ----- rtl/pip_vtx_mem.sv -----
`timescale 1ns / 1ps

module pip_vtx_mem #(
    parameter int DEPTH = pip_pkg::MAX_VERTICES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  pip_pkg::t_pip_vtx i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output pip_pkg::t_pip_vtx o_rdata
);

    pip_pkg::t_pip_vtx r_mem [DEPTH];
    pip_pkg::t_pip_vtx r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/pip_edge_unit.sv -----
`timescale 1ns / 1ps

module pip_edge_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic signed [15:0] i_px,
    input  logic signed [15:0] i_py,
    input  pip_pkg::t_pip_edge i_edge,
    output pip_pkg::t_pip_sts  o_sts
);

    pip_pkg::t_pip_vtx lo, hi;
    logic              in_rng;

    logic               r_v1, r_v2, r_v3;
    logic               r_rng1, r_rng2, r_hit;
    logic signed [16:0] r_d1, r_d2, r_d3, r_d4;
    logic signed [33:0] r_lhs, r_rhs;

    // order endpoints by y, lower end first
    always_comb begin
        if (i_edge.pb.y >= i_edge.pa.y) begin
            lo = i_edge.pa;
            hi = i_edge.pb;
        end else begin
            lo = i_edge.pb;
            hi = i_edge.pa;
        end
        in_rng = (i_py < hi.y) && (i_py >= lo.y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_edge.vld;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        // differences
        r_rng1 <= in_rng;
        r_d1   <= {i_py[15], i_py} - {lo.y[15], lo.y};
        r_d2   <= {hi.x[15], hi.x} - {lo.x[15], lo.x};
        r_d3   <= {i_px[15], i_px} - {lo.x[15], lo.x};
        r_d4   <= {hi.y[15], hi.y} - {lo.y[15], lo.y};
        // cross products
        r_rng2 <= r_rng1;
        r_lhs  <= r_d1 * r_d2;
        r_rhs  <= r_d3 * r_d4;
        // edge x at query y is at least query x
        r_hit  <= r_rng2 && (r_lhs >= r_rhs);
    end

    assign o_sts.busy    = r_v1 | r_v2 | r_v3;
    assign o_sts.hit_vld = r_v3;
    assign o_sts.hit     = r_hit;

endmodule

// ----- rtl/point_in_polygon_test_core.sv -----
`timescale 1ns / 1ps
// point-in-polygon test by crossing count over one stored closed polygon
//
// request channel: i_req is taken at a rising edge with start high and busy low.
//   clear drops all vertices and the overflow flag; append stores a vertex, or
//   sets the sticky overflow flag once MAX_VERTICES are held; query tests a point.
// clear and append never raise busy, so another request may follow.
// a query raises busy until its result is shown; with n stored vertices
//   the vertex memory is read once per cycle, last vertex first then 0 to n-1,
//   and each pair feeds a shared three-stage cross-multiply unit, one edge a cycle.
//   an empty polygon reads no vertices and answers outside.
// result channel: o_res is shown for one cycle with o_valid high, in the cycle
//   busy falls; the receiver cannot stall, so it must take it then.
// clear, append and unused codes give no result.
// reset (synchronous, i_rst_n low) empties the polygon and clears the overflow
//   flag; vertex memory contents are left as they are and never read unwritten.
module point_in_polygon_test_core #(
    parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  pip_pkg::t_pip_req i_req,
    output logic              o_valid,
    output pip_pkg::t_pip_res o_res
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int NW = $clog2(MAX_VERTICES + 1);
    localparam int CW = $clog2(MAX_VERTICES + 2);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state             r_state;
    logic [NW-1:0]      r_cnt;
    logic               r_ovf;
    logic [CW-1:0]      r_rd_cnt;
    logic               r_rd_vld;
    logic               r_rd_first;
    logic               r_par;
    logic signed [15:0] r_px, r_py;
    pip_pkg::t_pip_vtx  r_prev;
    logic               r_valid;
    pip_pkg::t_pip_res  r_res;

    logic               accept;
    logic               we;
    pip_pkg::t_pip_vtx  wdata;
    logic               rd_go;
    logic               done;
    logic [NW-1:0]      last_idx;
    logic [CW-1:0]      rd_prev;
    logic [AW-1:0]      rd_addr;
    pip_pkg::t_pip_vtx  rdata;
    pip_pkg::t_pip_edge edge_in;
    pip_pkg::t_pip_sts  sts;

    assign accept   = start && (r_state == S_IDLE);
    assign we       = accept && (i_req.operation == pip_pkg::OP_APPEND)
                      && (r_cnt < NW'(MAX_VERTICES));
    assign wdata.x  = i_req.coord_x;
    assign wdata.y  = i_req.coord_y;

    // n + 1 reads: closing vertex, then every vertex in order
    assign rd_go    = (r_state == S_RUN) && (r_cnt != '0) && (r_rd_cnt <= CW'(r_cnt));
    assign last_idx = r_cnt - 1'b1;
    assign rd_prev  = r_rd_cnt - 1'b1;
    assign rd_addr  = (r_rd_cnt == '0) ? last_idx[AW-1:0] : rd_prev[AW-1:0];
    assign done     = (r_state == S_RUN) && !rd_go && !r_rd_vld && !sts.busy;

    assign edge_in.vld = r_rd_vld && !r_rd_first;
    assign edge_in.pa  = r_prev;
    assign edge_in.pb  = rdata;

    pip_vtx_mem #(
        .DEPTH (MAX_VERTICES),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (wdata),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    pip_edge_unit u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_px    (r_px),
        .i_py    (r_py),
        .i_edge  (edge_in),
        .o_sts   (sts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovf    <= 1'b0;
            r_rd_cnt <= '0;
            r_rd_vld <= 1'b0;
            r_par    <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_valid  <= 1'b0;
            r_rd_vld <= rd_go;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (i_req.operation)
                            pip_pkg::OP_CLEAR: begin
                                r_cnt <= '0;
                                r_ovf <= 1'b0;
                            end
                            pip_pkg::OP_APPEND: begin
                                if (we) begin
                                    r_cnt <= r_cnt + 1'b1;
                                end else begin
                                    r_ovf <= 1'b1;
                                end
                            end
                            pip_pkg::OP_QUERY: begin
                                r_rd_cnt <= '0;
                                r_par    <= 1'b0;
                                r_state  <= S_RUN;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_RUN: begin
                    if (rd_go) begin
                        r_rd_cnt <= r_rd_cnt + 1'b1;
                    end
                    if (sts.hit_vld && sts.hit) begin
                        r_par <= ~r_par;
                    end
                    if (done) begin
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
        // payload registers
        if (accept) begin
            r_px <= i_req.coord_x;
            r_py <= i_req.coord_y;
        end
        r_rd_first <= (r_rd_cnt == '0);
        if (r_rd_vld) begin
            r_prev <= rdata;
        end
        if (done) begin
            r_res.inside_res <= r_par;
            r_res.overflowed <= r_ovf;
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ----- rtl/pip_chk.sv -----
`timescale 1ns / 1ps

module pip_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input pip_pkg::t_pip_req i_req,
    input logic              o_valid,
    input pip_pkg::t_pip_res o_res
);

    logic acc_query;
    logic acc_other;

    assign acc_query = start && !busy && (i_req.operation == pip_pkg::OP_QUERY);
    assign acc_other = start && !busy && (i_req.operation != pip_pkg::OP_QUERY);

    // a query always occupies the block
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_query |=> busy)
        else $error("query accepted but busy not raised");

    // other requests leave the block idle and give no result
    a_other_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_other |=> (!busy && !o_valid))
        else $error("clear or append left the block busy or gave a result");

    // a result ends a query
    a_res_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!busy && $past(busy)))
        else $error("result strobe outside the end of a query");

    // one result per query
    a_res_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe repeated");

    // a query right after a clear answers outside, with the overflow flag cleared
    a_ovf_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req.operation == pip_pkg::OP_CLEAR)) ##1
        (start && !busy && (i_req.operation == pip_pkg::OP_QUERY))
        |-> ##2 (o_valid && !o_res.overflowed && !o_res.inside_res))
        else $error("query on a cleared polygon answered wrongly");

endmodule

bind point_in_polygon_test_core pip_chk u_pip_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_req   (i_req),
    .o_valid (o_valid),
    .o_res   (o_res)
);
